// ===== rtl/core/dfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal fixed-point divider package
// Shared constants and the control struct of the shared adder.
// ----------------------------------------------------------------------------
package dfpd_pkg;

  // Width of the fractional digit count register.
  localparam int unsigned DIGIT_W = 5;

  // Largest digit count that takes effect; larger settings saturate here.
  localparam logic [DIGIT_W-1:0] MAX_DIGITS = 5'd18;

  // Digit count after reset.
  localparam logic [DIGIT_W-1:0] DIGITS_RESET = 5'd3;

  // Bits needed to hold ten to the power of the largest digit count.
  localparam int unsigned SCALE_W = 60;

  // Configuration register indexes.
  localparam logic REG_FRAC_DIGITS = 1'b0;

  // Controls of the shared adder: sum = a + (inv_b ? ~b : b) + cin.
  typedef struct packed {
    logic inv_b;
    logic cin;
  } alu_ctl_t;

endpackage

// ===== rtl/core/dfpd_adder.sv =====
// ----------------------------------------------------------------------------
// Shared adder
// One wide add/subtract unit that every step of the divider goes through.
// ----------------------------------------------------------------------------
module dfpd_adder #(
  parameter int unsigned WIDTH = 125
) (
  input  logic [WIDTH-1:0] op_a_i,
  input  logic [WIDTH-1:0] op_b_i,
  input  dfpd_pkg::alu_ctl_t ctl_i,
  output logic [WIDTH-1:0] sum_o
);

  logic [WIDTH-1:0] op_b_eff;

  // Invert the second operand for subtraction, carry in completes the negate.
  assign op_b_eff = ctl_i.inv_b ? ~op_b_i : op_b_i;
  assign sum_o    = op_a_i + op_b_eff + WIDTH'(ctl_i.cin);

endmodule

// ===== rtl/core/decimal_fixed_point_divider_unit.sv =====
// ----------------------------------------------------------------------------
// Decimal fixed-point divider
// Divides two signed scaled integers and rounds the quotient half away from zero.
// ----------------------------------------------------------------------------
// After acceptance all arithmetic runs through one shared adder: the
// sequencer takes the operand magnitudes, multiplies the dividend magnitude
// by ten once per fractional digit (the digit count saturates at 18) and
// clears the remainder, runs the restoring division one quotient bit at a
// time, rounds, checks overflow and applies the sign, and hands the result
// to the output register. A zero dividend, a zero divisor or a NaN operand
// skips the arithmetic and goes straight to the hand-off step. The next item
// can be accepted once a result has moved to the output register, even while
// that result is still stalled there.
module decimal_fixed_point_divider_unit #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] quotient_o,
  output logic        is_nan_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Numerator width holds the magnitude times ten to the eighteenth.
  localparam int unsigned NUM_W = DATA_WIDTH + dfpd_pkg::SCALE_W;
  localparam int unsigned AW    = NUM_W + 1;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [DATA_WIDTH-1:0] NAN_VAL = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ABSA  = 4'd1;
  localparam logic [3:0] S_ABSB  = 4'd2;
  localparam logic [3:0] S_SCALE = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_RCMP  = 4'd5;
  localparam logic [3:0] S_RINC  = 4'd6;
  localparam logic [3:0] S_SIGN  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]                   state_q, state_d;
  logic [dfpd_pkg::DIGIT_W-1:0] frac_q;
  logic [DATA_WIDTH-1:0]        a_q, b_q, bm_q, rem_q;
  logic [NUM_W-1:0]             num_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         neg_q, rup_q, ovf_q;
  logic [DATA_WIDTH-1:0]        res_q;
  logic                         res_nan_q;
  logic                         out_valid_q;
  logic [DATA_WIDTH-1:0]        out_q;
  logic                         out_nan_q;

  logic [DATA_WIDTH-1:0]        in_a, in_b, rem_shift;
  logic                         in_accept, cfg_write, out_free;
  logic [AW-1:0]                alu_a, alu_b, alu_sum;
  dfpd_pkg::alu_ctl_t           alu_ctl;
  logic                         diff_neg;

  // Operands use only their low DATA_WIDTH bits.
  assign in_a      = dividend_i[DATA_WIDTH-1:0];
  assign in_b      = divisor_i[DATA_WIDTH-1:0];
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rem_shift = {rem_q[DATA_WIDTH-2:0], num_q[NUM_W-1]};
  assign diff_neg  = alu_sum[AW-1];

  // Configuration register access.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == dfpd_pkg::REG_FRAC_DIGITS) ?
                     32'(frac_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= dfpd_pkg::DIGITS_RESET;
    end else if (cfg_write && (paddr[2] == dfpd_pkg::REG_FRAC_DIGITS)) begin
      frac_q <= pwdata[dfpd_pkg::DIGIT_W-1:0];
    end
  end

  // Operand selection for the shared adder in each step.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_ctl = '{inv_b: 1'b1, cin: 1'b1};
    case (state_q)
      S_ABSA: begin
        alu_b = AW'(a_q);
      end
      S_ABSB: begin
        alu_b = AW'(b_q);
      end
      S_SCALE: begin
        // Times ten as eight times plus two times.
        alu_a   = AW'({num_q, 3'b000});
        alu_b   = AW'({num_q, 1'b0});
        alu_ctl = '{inv_b: 1'b0, cin: 1'b0};
      end
      S_DIV: begin
        alu_a = AW'(rem_shift);
        alu_b = AW'(bm_q);
      end
      S_RCMP: begin
        // Twice the remainder against the divisor decides rounding up.
        alu_a = AW'({rem_q, 1'b0});
        alu_b = AW'(bm_q);
      end
      S_RINC: begin
        alu_a   = AW'(num_q);
        alu_ctl = '{inv_b: 1'b0, cin: rup_q};
      end
      S_SIGN: begin
        alu_b = AW'(num_q);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  dfpd_adder #(
    .WIDTH (AW)
  ) u_adder (
    .op_a_i (alu_a),
    .op_b_i (alu_b),
    .ctl_i  (alu_ctl),
    .sum_o  (alu_sum)
  );

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if ((in_a == '0) || (in_b == '0) || (in_a == NAN_VAL) || (in_b == NAN_VAL)) begin
            state_d = S_OUT;
          end else begin
            state_d = S_ABSA;
          end
        end
      end
      S_ABSA:  state_d = S_ABSB;
      S_ABSB:  state_d = S_SCALE;
      S_SCALE: begin
        if (cnt_q == '0) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_q == '0) begin
          state_d = S_RCMP;
        end
      end
      S_RCMP:  state_d = S_RINC;
      S_RINC:  state_d = S_SIGN;
      S_SIGN:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        a_q   <= in_a;
        b_q   <= in_b;
        neg_q <= in_a[DATA_WIDTH-1] ^ in_b[DATA_WIDTH-1];
        // Zero dividend wins over every other special case.
        if (in_a == '0) begin
          res_q     <= '0;
          res_nan_q <= 1'b0;
        end else begin
          res_q     <= NAN_VAL;
          res_nan_q <= 1'b1;
        end
      end
      S_ABSA: begin
        num_q <= NUM_W'(a_q[DATA_WIDTH-1] ? alu_sum[DATA_WIDTH-1:0] : a_q);
      end
      S_ABSB: begin
        bm_q  <= b_q[DATA_WIDTH-1] ? alu_sum[DATA_WIDTH-1:0] : b_q;
        cnt_q <= (frac_q > dfpd_pkg::MAX_DIGITS) ? CNT_W'(dfpd_pkg::MAX_DIGITS) :
                 CNT_W'(frac_q);
      end
      S_SCALE: begin
        if (cnt_q == '0) begin
          rem_q <= '0;
          cnt_q <= DIV_LAST;
        end else begin
          num_q <= alu_sum[NUM_W-1:0];
          cnt_q <= cnt_q - 1'b1;
        end
      end
      S_DIV: begin
        // Restoring step: keep the difference when it does not go negative.
        rem_q <= diff_neg ? rem_shift : alu_sum[DATA_WIDTH-1:0];
        num_q <= {num_q[NUM_W-2:0], !diff_neg};
        cnt_q <= cnt_q - 1'b1;
      end
      S_RCMP: begin
        rup_q <= !diff_neg;
      end
      S_RINC: begin
        num_q <= alu_sum[NUM_W-1:0];
        ovf_q <= |alu_sum[AW-1:DATA_WIDTH-1];
      end
      S_SIGN: begin
        if (ovf_q) begin
          res_q     <= NAN_VAL;
          res_nan_q <= 1'b1;
        end else begin
          res_q     <= neg_q ? alu_sum[DATA_WIDTH-1:0] : num_q[DATA_WIDTH-1:0];
          res_nan_q <= 1'b0;
        end
      end
      default: begin
        rup_q <= rup_q;
      end
    endcase
  end

  // Output register, loaded when a finished result finds it free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_q     <= res_q;
      out_nan_q <= res_nan_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quotient_o  = 64'($signed(out_q));
  assign is_nan_o    = out_nan_q;

  // An accepted item always leaves the sequencer busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("sequencer did not leave idle after accepting an item");

  // A NaN result always carries the NaN pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_nan_o) |-> (out_q == NAN_VAL))
    else $error("NaN result without the NaN pattern");

  // A result moves to the output register only when that register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_free) |=> (state_q == S_OUT))
    else $error("result left the sequencer while the output was stalled");

  // The rounding step follows the last division step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RCMP) |-> ($past(state_q) == S_DIV && $past(cnt_q) == '0))
    else $error("rounding started before the division finished");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Decimal fixed-point divider testbench
// Drives operand pairs under random gaps and output stalls across several
// digit count settings, predicts each rounded quotient with 128-bit
// arithmetic and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [63:0] NAN_VAL  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_MAG  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_REAL = 64'h8000_0000_0000_0001;
  localparam logic [63:0] MINUS_1  = 64'hFFFF_FFFF_FFFF_FFFF;

  // Cycles without any accepted item or register access before the run is declared hung.
  localparam int unsigned IDLE_LIMIT = 5000;
  // Length of each deliberate output hold-off, and when it starts.
  localparam int unsigned HOLD_CYCLES = 700;
  localparam int unsigned HOLD_AT_0 = 30;
  localparam int unsigned HOLD_AT_1 = 450;
  localparam int unsigned ITEMS_PER_PHASE = 90;
  localparam int unsigned NUM_PHASES = 9;
  localparam int unsigned DRAIN_CYCLES = 200;

  // Digit count per phase: -1 leaves the setting as it is, -2 picks one at random.
  localparam int PHASE_DIGITS [NUM_PHASES] = '{-1, 0, 18, 31, 1, 12, 19, -2, -2};

  typedef struct packed {
    logic [63:0] dividend;
    logic [63:0] divisor;
  } operand_pair_t;

  typedef struct {
    logic [63:0] quotient;
    logic        is_nan;
  } quotient_t;

  // Directed pairs, all run at the reset digit count of three.
  localparam int unsigned NUM_DIRECTED = 25;
  localparam operand_pair_t DIRECTED [NUM_DIRECTED] = '{
    '{64'd0, 64'd0},              // zero over zero gives zero
    '{64'd0, NAN_VAL},            // zero over NaN gives zero
    '{NAN_VAL, 64'd0},
    '{64'd5000, 64'd0},           // division by zero
    '{NAN_VAL, 64'd1000},
    '{64'd1000, NAN_VAL},
    '{NAN_VAL, NAN_VAL},
    '{64'd1000, 64'd1000},
    '{-64'sd1000, 64'd1000},
    '{64'd1000, -64'sd1000},
    '{-64'sd1000, -64'sd1000},
    '{64'd1, 64'd2000},           // exact half rounds up
    '{-64'sd1, 64'd2000},         // exact half rounds away from zero
    '{-64'sd1, 64'd3000},         // negative result rounding to zero
    '{MAX_MAG, MAX_MAG},
    '{MIN_REAL, MAX_MAG},
    '{MAX_MAG, 64'd1},            // overflow
    '{MAX_MAG, 64'd1000},         // largest result that fits
    '{64'd1, MAX_MAG},
    '{MIN_REAL, MINUS_1},         // overflow with a negative divisor
    '{64'd9223372036854775, 64'd1},
    '{64'd9223372036854776, 64'd1},
    '{64'd7, 64'd3},
    '{-64'sd2, 64'd3},
    '{64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAB}
  };

  // Predicts each quotient and checks results against the predictions.
  class quotient_board;
    logic [dfpd_pkg::DIGIT_W-1:0] frac_digits;
    quotient_t pending_quotients[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      frac_digits = dfpd_pkg::DIGITS_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    // Work out the rounded quotient of an accepted operand pair.
    function void note_division(logic [63:0] dividend, logic [63:0] divisor);
      quotient_t    want;
      logic [63:0]  mag_a, mag_b, rem;
      logic [127:0] scale, product, quo;
      int unsigned  digits;
      logic         negative;
      want.quotient = 64'd0;
      want.is_nan = 1'b0;
      if (dividend == 64'd0) begin
        // Zero dividend wins over every other special case.
      end else if (divisor == 64'd0 || dividend == NAN_VAL || divisor == NAN_VAL) begin
        want.quotient = NAN_VAL;
        want.is_nan = 1'b1;
      end else begin
        negative = dividend[63] ^ divisor[63];
        mag_a = dividend[63] ? 64'd0 - dividend : dividend;
        mag_b = divisor[63] ? 64'd0 - divisor : divisor;
        digits = (frac_digits > dfpd_pkg::MAX_DIGITS) ? dfpd_pkg::MAX_DIGITS : frac_digits;
        scale = 128'd1;
        for (int i = 0; i < digits; i++) begin
          scale = scale * 128'd10;
        end
        product = {64'd0, mag_a} * scale;
        quo = product / {64'd0, mag_b};
        rem = 64'(product - quo * {64'd0, mag_b});
        // Round half up on the remainder.
        if (rem >= mag_b - rem) begin
          quo = quo + 128'd1;
        end
        if (quo > {64'd0, MAX_MAG}) begin
          want.quotient = NAN_VAL;
          want.is_nan = 1'b1;
        end else begin
          want.quotient = negative ? 64'd0 - quo[63:0] : quo[63:0];
        end
      end
      pending_quotients.push_back(want);
    endfunction

    // Compare one result with the oldest prediction.
    function void check_result(logic [63:0] quotient, logic is_nan);
      quotient_t want;
      checked++;
      if (pending_quotients.size() == 0) begin
        $error("quotient: unexpected result %0d with is_nan %0b", $signed(quotient), is_nan);
        mismatches++;
        return;
      end
      want = pending_quotients.pop_front();
      if (quotient !== want.quotient) begin
        $error("quotient: expected %0d, actual %0d", $signed(want.quotient), $signed(quotient));
        mismatches++;
      end
      if (is_nan !== want.is_nan) begin
        $error("is_nan: expected %0b, actual %0b", want.is_nan, is_nan);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] dividend_i;
  logic [63:0] divisor_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] quotient_o;
  logic        is_nan_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  quotient_board board = new();
  int unsigned   idle_cycles = 0;

  decimal_fixed_point_divider_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dividend_i  (dividend_i),
    .divisor_i   (divisor_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .quotient_o  (quotient_o),
    .is_nan_o    (is_nan_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(1, 3);
    if (pick < 92) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random operand: specials, values of random length, or full-width noise.
  function automatic logic [63:0] random_operand();
    logic [63:0] value;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    value = {$urandom, $urandom};
    if (pick < 3) begin
      value = 64'd0;
    end else if (pick < 5) begin
      value = NAN_VAL;
    end else if (pick < 7) begin
      value = MAX_MAG;
    end else if (pick < 9) begin
      value = MIN_REAL;
    end else if (pick < 12) begin
      value = $urandom_range(0, 1) ? 64'd1 : MINUS_1;
    end else if (pick < 80) begin
      value = value >> $urandom_range(1, 63);
      if ($urandom_range(0, 1)) value = 64'd0 - value;
    end
    return value;
  endfunction

  // Offer one item and hold it until it is taken.
  task automatic send_division(logic [63:0] dividend, logic [63:0] divisor);
    in_valid_i <= 1'b1;
    dividend_i <= dividend;
    divisor_i <= divisor;
    do @(posedge clk_i); while (in_stall_o);
    board.note_division(dividend, divisor);
  endtask

  // Drop valid for a number of cycles; zero keeps the next item back to back.
  task automatic sender_pause(int unsigned cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      dividend_i <= {$urandom, $urandom};
      divisor_i <= {$urandom, $urandom};
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Wait until every predicted quotient has been checked.
  task automatic drain_quotients();
    while (board.pending_quotients.size() != 0) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle of a register write.
  task automatic write_frac_digits(logic [dfpd_pkg::DIGIT_W-1:0] digits);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * dfpd_pkg::REG_FRAC_DIGITS);
    pwdata <= 32'(digits);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.frac_digits = digits;
  endtask

  // Stimulus: reset, directed pairs, then random phases at several settings.
  initial begin : stimulus
    int unsigned burst_left;
    int unsigned gap;
    int unsigned digits;
    logic [63:0] scale, mult, num, den;
    burst_left = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    dividend_i = 64'd0;
    divisor_i = 64'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_division(DIRECTED[i].dividend, DIRECTED[i].divisor);
      sender_pause($urandom_range(0, 1) ? 0 : idle_len());
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (PHASE_DIGITS[phase] != -1) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        drain_quotients();
        write_frac_digits(PHASE_DIGITS[phase] == -2 ? 5'($urandom_range(0, 31))
                                                   : 5'(PHASE_DIGITS[phase]));
      end
      digits = (board.frac_digits > dfpd_pkg::MAX_DIGITS) ? dfpd_pkg::MAX_DIGITS
                                                           : board.frac_digits;
      scale = 64'd1;
      for (int i = 0; i < digits; i++) scale = scale * 64'd10;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 10) begin
          // Operands whose scaled ratio is an odd number of halves.
          mult = 64'($urandom_range(1, 4));
          num = 64'($urandom_range(0, 49) * 2 + 1) * mult;
          den = 64'd2 * mult * scale;
          if ($urandom_range(0, 1)) num = 64'd0 - num;
          if ($urandom_range(0, 1)) den = 64'd0 - den;
        end else begin
          num = random_operand();
          den = random_operand();
        end
        send_division(num, den);
        if (burst_left == 0 && $urandom_range(0, 99) < 4) begin
          burst_left = $urandom_range(15, 40);
        end
        if (burst_left > 0) begin
          burst_left--;
          gap = 0;
        end else begin
          gap = ($urandom_range(0, 99) < 40) ? 0 : idle_len();
        end
        sender_pause(gap);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    drain_quotients();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Output stall pattern, with two long hold-offs that fill the block.
  initial begin : receiver
    int unsigned pick;
    int unsigned holds_done;
    holds_done = 0;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ((holds_done == 0 && board.checked >= HOLD_AT_0) ||
          (holds_done == 1 && board.checked >= HOLD_AT_1)) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          out_stall_i <= 1'b0;
          repeat ($urandom_range(1, 8) - 1) @(posedge clk_i);
        end else if (pick < 85) begin
          out_stall_i <= 1'b1;
          repeat (idle_len() - 1) @(posedge clk_i);
        end else begin
          // Stretch with no stalling at all.
          out_stall_i <= 1'b0;
          repeat ($urandom_range(20, 150)) @(posedge clk_i);
        end
      end
    end
  end

  // Check each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_result(quotient_o, is_nan_o);
    end
  end

  // Watchdog on cycles in which nothing at all is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
